FILE: rtl/core/mru_page_buffer_policy_defines.svh
// ----------------------------------------------------------------------------
// MRU page buffer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MRU_PAGE_BUFFER_POLICY_DEFINES_SVH
`define MRU_PAGE_BUFFER_POLICY_DEFINES_SVH

// same-cycle implication
`define MPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mpb_pkg.sv
// ----------------------------------------------------------------------------
// MRU page buffer package
// Sizes, transaction types and field conversion helpers.
// ----------------------------------------------------------------------------
package mpb_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = $clog2(FRAMES);

  typedef logic [FRAME_W-1:0]   frame_idx_t;
  typedef logic [PAGE_BITS-1:0] tag_t;

  typedef struct packed {
    logic [15:0] page;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame;
    logic        evicted;
    logic [15:0] old_page;
    logic        write_back;
  } out_t;

  function automatic tag_t page_to_tag(input logic [15:0] p);
    tag_t t;
    t = '0;
    for (int i = 0; i < PAGE_BITS; i++) begin
      if (i < 16) t[i] = p[i];
    end
    return t;
  endfunction

  function automatic logic [15:0] tag_to_page(input tag_t t);
    logic [15:0] p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < PAGE_BITS) p[i] = t[i];
    end
    return p;
  endfunction

  function automatic logic [3:0] idx_to_frame(input frame_idx_t f);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < FRAME_W) r[i] = f[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mpb_page_ram.sv
// ----------------------------------------------------------------------------
// MRU page buffer tag RAM
// Page number per frame; one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpb_page_ram (
  input  logic                clk,
  input  logic                we,
  input  mpb_pkg::frame_idx_t waddr,
  input  mpb_pkg::tag_t       wdata,
  input  mpb_pkg::frame_idx_t raddr,
  output mpb_pkg::tag_t       rdata
);

  mpb_pkg::tag_t mem [mpb_pkg::FRAMES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mru_page_buffer_policy.sv
// ----------------------------------------------------------------------------
// MRU page buffer policy
// Frame lookup, fill and MRU eviction with one shared tag compare.
// ----------------------------------------------------------------------------
//  channel   dir  payload            handshake
//  in        in   mpb_pkg::in_t      in_valid / in_ready
//  out       out  mpb_pkg::out_t     out_valid / out_ready
//
//  One tag compare steps down the frames, a RAM read then a compare per
//  frame, highest frame first. A hit on frame k ends the scan early; a
//  miss scans every frame, and an eviction then reads the victim's old page.
//  in_ready is high only while idle; a pending result stalls the final
//  update step until out_ready. Reset clears valid and dirty marks at once.
// ----------------------------------------------------------------------------
module mru_page_buffer_policy (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mpb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mpb_pkg::out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_RD_OLD,
    S_OLD,
    S_FIN
  } state_t;

  state_t                    state;
  mpb_pkg::tag_t             pg;
  logic                      wr;
  mpb_pkg::frame_idx_t       idx;
  mpb_pkg::frame_idx_t       vic;
  mpb_pkg::frame_idx_t       free_idx;
  mpb_pkg::frame_idx_t       last_used;
  logic                      found_free;
  logic                      match;
  logic                      evict;
  mpb_pkg::tag_t             old_tag;
  logic [mpb_pkg::FRAMES-1:0] valid;
  logic [mpb_pkg::FRAMES-1:0] dirty;

  mpb_pkg::frame_idx_t       raddr;
  mpb_pkg::tag_t             rdata;
  logic                      ram_we;
  logic                      out_free;
  logic                      tag_eq;
  logic                      free_now;
  mpb_pkg::frame_idx_t       free_sel;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign raddr    = (state == S_RD_OLD) ? vic : idx;
  assign ram_we   = (state == S_FIN) && out_free && !match;
  assign tag_eq   = valid[idx] && (rdata == pg);
  assign free_now = found_free || !valid[idx];
  assign free_sel = found_free ? free_idx : idx;

  mpb_page_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vic),
    .wdata (pg),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      valid      <= '0;
      dirty      <= '0;
      last_used  <= '0;
      match      <= 1'b0;
      evict      <= 1'b0;
      found_free <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pg         <= mpb_pkg::page_to_tag(in_data.page);
            wr         <= in_data.is_write;
            idx        <= mpb_pkg::FRAME_W'(mpb_pkg::FRAMES - 1);
            match      <= 1'b0;
            evict      <= 1'b0;
            found_free <= 1'b0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (tag_eq) begin
            match <= 1'b1;
            vic   <= idx;
            state <= S_FIN;
          end else begin
            if (!valid[idx] && !found_free) begin
              found_free <= 1'b1;
              free_idx   <= idx;
            end
            if (idx == '0) begin
              if (free_now) begin
                vic   <= free_sel;
                state <= S_FIN;
              end else begin
                vic   <= last_used;
                state <= S_RD_OLD;
              end
            end else begin
              idx   <= idx - mpb_pkg::FRAME_W'(1);
              state <= S_RD;
            end
          end
        end
        S_RD_OLD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          old_tag <= rdata;
          evict   <= 1'b1;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.hit        <= match;
            out_data.frame      <= mpb_pkg::idx_to_frame(vic);
            out_data.evicted    <= evict;
            out_data.old_page   <= evict ? mpb_pkg::tag_to_page(old_tag) : 16'd0;
            out_data.write_back <= evict && dirty[vic];
            valid[vic]          <= 1'b1;
            dirty[vic]          <= match ? (dirty[vic] || wr) : wr;
            last_used           <= vic;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/mpb_checker.sv
// ----------------------------------------------------------------------------
// MRU page buffer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "mru_page_buffer_policy_defines.svh"

module mpb_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input mpb_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input mpb_pkg::out_t out_data
);

  `MPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out transaction changed while stalled")
  `MPB_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "in_ready stayed high after accept")
  `MPB_ASSERT_NOW(a_no_evict_zero, out_valid && !out_data.evicted, out_data.old_page == 16'd0 && !out_data.write_back, "eviction fields set without eviction")
  `MPB_ASSERT_NOW(a_hit_no_evict, out_valid && out_data.hit, !out_data.evicted, "hit reported with eviction")

endmodule

bind mru_page_buffer_policy mpb_checker u_mpb_checker (.*);
